@@ hw/rtl/cvkf_pkg.sv @@
package cvkf_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_PROC_NOISE  = 3'd0;
	localparam logic [2:0] REG_MEAS_NOISE  = 3'd1;
	localparam logic [2:0] REG_SAMPLE_PER  = 3'd2;
	localparam logic [2:0] REG_ALL_AXES    = 3'd3;
	localparam logic [2:0] REG_FIXED_GAIN  = 3'd4;
	localparam logic [2:0] REG_GAIN_VALUE  = 3'd5;
	localparam logic [2:0] REG_GAIN_RATE   = 3'd6;

	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = -32'sh7fffffff - 32'sd1;

	// ALU operations
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2
	} alu_op_t;

	// Saturate a 34-bit sum into 32 bits
	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		begin
			if (v > 34'sd2147483647) r = SAT_MAX;
			else if (v < -34'sd2147483648) r = SAT_MIN;
			else r = v[31:0];
			return r;
		end
	endfunction

endpackage

@@ hw/rtl/cvkf_alu.sv @@
// Shared saturating Q16.16 add / sub / multiply, one registered result per op.
// The multiply is split: 32x32 product registered, then shift and saturate.
module cvkf_alu import cvkf_pkg::*; (
	input  logic               clk,
	input  logic               start,
	input  alu_op_t            op,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [31:0] res_q
);
	logic signed [63:0] prod_s1;
	logic               mul_s1;
	logic signed [31:0] addres_s1;
	logic signed [63:0] shr;
	logic signed [63:0] lim;
	logic signed [33:0] sum;

	always_comb begin
		if (op == OP_SUB) sum = 34'(a) - 34'(b);
		else sum = 34'(a) + 34'(b);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1   <= a * b;
			mul_s1    <= (op == OP_MUL);
			addres_s1 <= sat34(sum);
		end
	end

	// arithmetic shift is floor, matching rounding toward minus infinity
	assign shr = prod_s1 >>> 16;

	always_comb begin
		lim = shr;
		if (shr > 64'sd2147483647) lim = 64'(SAT_MAX);
		else if (shr < -64'sd2147483648) lim = 64'(SAT_MIN);
	end

	assign res_q = mul_s1 ? lim[31:0] : addres_s1;
endmodule

@@ hw/rtl/cvkf_div.sv @@
// Radix-2 restoring divider: sat((n<<16)/d), truncating toward zero.
// One quotient bit per cycle while busy; the quotient has 48 bits.
module cvkf_div import cvkf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done_q,
	output logic signed [31:0] quo_q
);
	logic [47:0] dvd_q;
	logic [47:0] quo_acc_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;
	logic [32:0] rem_sh;
	logic [48:0] qmag;
	logic signed [49:0] qs;

	assign rem_sh = {rem_q, dvd_q[47]};
	assign trial  = rem_sh - {1'b0, dvs_q};
	assign qmag   = {1'b0, quo_acc_q};
	assign qs     = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q     <= {(num[31] ? 32'(-33'(num)) : 32'(num)), 16'd0};
			dvs_q     <= den[31] ? 32'(-33'(den)) : 32'(den);
			neg_q     <= num[31] ^ den[31];
			rem_q     <= '0;
			quo_acc_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[46:0], 1'b0};
			if (!trial[32]) begin
				rem_q     <= trial[31:0];
				quo_acc_q <= {quo_acc_q[46:0], 1'b1};
			end else begin
				rem_q     <= rem_sh[31:0];
				quo_acc_q <= {quo_acc_q[46:0], 1'b0};
			end
		end
	end

	// zero divisor gives zero gain
	always_comb begin
		if (dvs_q == 32'd0) quo_q = '0;
		else if (qs > 50'sd2147483647) quo_q = SAT_MAX;
		else if (qs < -50'sd2147483648) quo_q = SAT_MIN;
		else quo_q = qs[31:0];
	end
endmodule

@@ hw/rtl/const_velocity_kalman_filter.sv @@
// Fixed-gain mode skips prediction, the gain divides and the covariance update.
// Each shared ALU op passes through the issue, wait and done states; the two gain divides
// run one after the other. A new sample is taken only once the last one is through.
// The result sits in output registers, so the next sample is taken while it waits;
// a later result waits until it is taken.
// Reset (arst_n low) clears estimates and covariance and restores register defaults.
module const_velocity_kalman_filter import cvkf_pkg::*; #(
	parameter int AXES = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] meas_x,
	input  logic signed [15:0] meas_y,
	input  logic signed [15:0] meas_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value_x,
	output logic signed [31:0] value_y,
	output logic signed [31:0] value_z,
	output logic signed [31:0] rate_x,
	output logic signed [31:0] rate_y,
	output logic signed [31:0] rate_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	// microprogram: scratch registers, each op reads two and writes one
	typedef enum logic [4:0] {
		R_ZERO, R_T, R_R, R_Q, R_P00, R_P01, R_P11, R_TP01, R_TT, R_A, R_B,
		R_PP00, R_PP01, R_PP11, R_DEN, R_K0, R_K1, R_OM, R_V, R_RT, R_Z,
		R_PRED, R_INN, R_C, R_ONE, R_K1P
	} reg_id_t;
	localparam int NREG = 26;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ISSUE = 6'b000010,
		S_WAIT  = 6'b000100,
		S_DIV   = 6'b001000,
		S_DONE  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	typedef struct packed {
		alu_op_t op;
		reg_id_t a;
		reg_id_t b;
		reg_id_t d;
	} uop_t;

	localparam int NPRED = 11;
	localparam int NAX   = 8;
	localparam int NCOV  = 20;

	function automatic uop_t pred_uop(input logic [3:0] i);
		case (i)
			4'd0:  return '{OP_MUL, R_T, R_P01, R_TP01};
			4'd1:  return '{OP_ADD, R_TP01, R_TP01, R_A};
			4'd2:  return '{OP_ADD, R_P00, R_A, R_A};
			4'd3:  return '{OP_MUL, R_T, R_T, R_TT};
			4'd4:  return '{OP_MUL, R_TT, R_P11, R_B};
			4'd5:  return '{OP_ADD, R_A, R_B, R_PP00};
			4'd6:  return '{OP_MUL, R_T, R_P11, R_B};
			4'd7:  return '{OP_ADD, R_P01, R_B, R_PP01};
			4'd8:  return '{OP_ADD, R_P11, R_Q, R_PP11};
			4'd9:  return '{OP_ADD, R_PP00, R_R, R_DEN};
			default: return '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
		endcase
	endfunction

	function automatic uop_t ax_uop(input logic [2:0] i);
		case (i)
			3'd0: return '{OP_MUL, R_T, R_RT, R_A};
			3'd1: return '{OP_ADD, R_V, R_A, R_PRED};
			3'd2: return '{OP_SUB, R_Z, R_PRED, R_INN};
			3'd3: return '{OP_MUL, R_K0, R_INN, R_A};
			3'd4: return '{OP_ADD, R_PRED, R_A, R_V};
			3'd5: return '{OP_MUL, R_K1, R_INN, R_A};
			3'd6: return '{OP_ADD, R_RT, R_A, R_RT};
			default: return '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
		endcase
	endfunction

	function automatic uop_t cov_uop(input logic [4:0] i);
		case (i)
			5'd0:  return '{OP_SUB, R_ONE, R_K0, R_OM};
			5'd1:  return '{OP_MUL, R_K1, R_PP01, R_K1P};
			5'd2:  return '{OP_MUL, R_OM, R_OM, R_A};
			5'd3:  return '{OP_MUL, R_A, R_PP00, R_A};
			5'd4:  return '{OP_MUL, R_K0, R_K0, R_B};
			5'd5:  return '{OP_MUL, R_B, R_R, R_B};
			5'd6:  return '{OP_ADD, R_A, R_B, R_C};
			5'd7:  return '{OP_MUL, R_K0, R_K1, R_A};
			5'd8:  return '{OP_MUL, R_A, R_DEN, R_A};
			5'd9:  return '{OP_MUL, R_OM, R_PP01, R_B};
			5'd10: return '{OP_ADD, R_A, R_B, R_A};
			5'd11: return '{OP_MUL, R_K1, R_PP00, R_B};
			5'd12: return '{OP_SUB, R_A, R_B, R_P01};
			5'd13: return '{OP_MUL, R_K1, R_K1, R_A};
			5'd14: return '{OP_MUL, R_A, R_DEN, R_A};
			5'd15: return '{OP_ADD, R_K1P, R_K1P, R_B};
			5'd16: return '{OP_SUB, R_A, R_B, R_A};
			5'd17: return '{OP_ADD, R_A, R_PP11, R_P11};
			5'd18: return '{OP_ADD, R_C, R_ZERO, R_P00};
			default: return '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
		endcase
	endfunction

	typedef enum logic [1:0] {PH_PRED, PH_AXIS, PH_COV} phase_t;

	logic signed [31:0] rf_q [NREG];
	logic signed [31:0] val_q [3];
	logic signed [31:0] rte_q [3];
	logic signed [31:0] out_val_q [3];
	logic signed [31:0] out_rte_q [3];
	logic signed [15:0] meas_q [3];
	logic [30:0] q_q, r_q, t_q;
	logic        all_q, fixed_q, div_k1_q;
	logic [16:0] gv_q, gr_q;
	state_t      st_q;
	phase_t      ph_q;
	logic [4:0]  pc_q;
	logic [1:0]  ax_q;
	logic [1:0]  nax;
	logic [1:0]  axis_id;
	uop_t        u;
	logic        alu_go, div_go, div_done;
	logic        div_busy_q;
	logic        out_free;
	logic signed [31:0] alu_res, div_res;

	assign nax = all_q ? 2'(AXES) : 2'd1;
	// process order y, x, z
	always_comb begin
		case (ax_q)
			2'd0: axis_id = 2'd1;
			2'd1: axis_id = 2'd0;
			default: axis_id = 2'd2;
		endcase
	end

	always_comb begin
		case (ph_q)
			PH_PRED: u = pred_uop(pc_q[3:0]);
			PH_AXIS: u = ax_uop(pc_q[2:0]);
			default: u = cov_uop(pc_q);
		endcase
	end

	assign alu_go = (st_q == S_ISSUE);
	cvkf_alu u_alu (
		.clk(clk), .start(alu_go), .op(u.op),
		.a(rf_q[u.a]), .b(rf_q[u.b]), .res_q(alu_res)
	);

	cvkf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go),
		.num(div_k1_q ? rf_q[R_PP01] : rf_q[R_PP00]), .den(rf_q[R_DEN]),
		.done_q(div_done), .quo_q(div_res)
	);
	assign div_go = (st_q == S_DIV) && !div_done && !div_busy_q;

	// output registers free when empty or being taken this cycle
	assign out_free  = !out_valid || !out_stall;
	assign in_stall  = (st_q != S_IDLE);
	assign cfg_ready = (st_q == S_IDLE) && !in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; ph_q <= PH_PRED; pc_q <= '0; ax_q <= '0;
			div_k1_q <= 1'b0; div_busy_q <= 1'b0; out_valid <= 1'b0;
			q_q <= 31'd655; r_q <= 31'd65536; t_q <= 31'd655;
			all_q <= 1'b1; fixed_q <= 1'b0; gv_q <= 17'd1628; gr_q <= 17'd20465;
			for (int i = 0; i < 3; i++) begin
				val_q[i] <= '0; rte_q[i] <= '0;
				out_val_q[i] <= '0; out_rte_q[i] <= '0;
			end
			for (int i = 0; i < NREG; i++) rf_q[i] <= '0;
		end else begin
			// result valid: set on load, cleared once taken
			if (st_q == S_OUT && out_free) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROC_NOISE: q_q <= cfg_data[30:0];
					REG_MEAS_NOISE: r_q <= cfg_data[30:0];
					REG_SAMPLE_PER: t_q <= cfg_data[30:0];
					REG_ALL_AXES:   all_q <= cfg_data[0];
					REG_FIXED_GAIN: fixed_q <= cfg_data[0];
					REG_GAIN_VALUE: gv_q <= cfg_data[16:0];
					REG_GAIN_RATE:  gr_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			case (st_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						meas_q[0] <= meas_x; meas_q[1] <= meas_y; meas_q[2] <= meas_z;
						rf_q[R_T]   <= {1'b0, t_q};
						rf_q[R_R]   <= {1'b0, r_q};
						rf_q[R_Q]   <= {1'b0, q_q};
						rf_q[R_ONE] <= ONE_Q16;
						rf_q[R_ZERO] <= '0;
						pc_q <= '0; ax_q <= '0;
						if (fixed_q) begin
							rf_q[R_K0] <= {15'd0, gv_q};
							rf_q[R_K1] <= {15'd0, gr_q};
							ph_q <= PH_AXIS;
						end else begin
							ph_q <= PH_PRED;
						end
						st_q <= S_DONE;
					end
				end
				S_ISSUE: st_q <= S_WAIT;
				S_WAIT: begin
					rf_q[u.d] <= alu_res;
					pc_q <= pc_q + 5'd1;
					st_q <= S_DONE;
				end
				S_DIV: begin
					if (!div_busy_q) div_busy_q <= 1'b1;
					if (div_done) begin
						div_busy_q <= 1'b0;
						if (div_k1_q) begin
							rf_q[R_K1] <= div_res;
							div_k1_q <= 1'b0;
							ph_q <= PH_AXIS; pc_q <= '0;
							st_q <= S_DONE;
						end else begin
							rf_q[R_K0] <= div_res;
							div_k1_q <= 1'b1;
						end
					end
				end
				S_DONE: begin
					// decide next micro-op or phase transition
					st_q <= S_ISSUE;
					case (ph_q)
						PH_PRED: if (pc_q == 5'(NPRED - 1)) st_q <= S_DIV;
						PH_AXIS: begin
							if (pc_q == 5'd0) begin
								rf_q[R_V]  <= val_q[axis_id];
								rf_q[R_RT] <= rte_q[axis_id];
								rf_q[R_Z]  <= {meas_q[axis_id], 16'd0};
							end else if (pc_q == 5'(NAX - 1)) begin
								val_q[axis_id] <= rf_q[R_V];
								rte_q[axis_id] <= rf_q[R_RT];
								pc_q <= '0;
								if (ax_q == nax - 2'd1) begin
									if (fixed_q) begin
										st_q <= S_OUT;
									end else begin
										ph_q <= PH_COV;
									end
								end else begin
									ax_q <= ax_q + 2'd1;
									st_q <= S_DONE;
								end
							end
						end
						default: if (pc_q == 5'(NCOV - 1)) st_q <= S_OUT;
					endcase
				end
				S_OUT: begin
					// hold until the previous result is taken
					if (out_free) begin
						for (int i = 0; i < 3; i++) begin
							out_val_q[i] <= val_q[i];
							out_rte_q[i] <= rte_q[i];
						end
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign value_x = out_val_q[0];
	assign value_y = out_val_q[1];
	assign value_z = out_val_q[2];
	assign rate_x  = out_rte_q[0];
	assign rate_y  = out_rte_q[1];
	assign rate_z  = out_rte_q[2];

	// no new sample while one is being worked on
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
	// result appears only after a finished step
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q == S_OUT)) else $error("spurious result");
	// configuration only while idle
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> (st_q == S_IDLE)) else $error("cfg while busy");
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import cvkf_pkg::*;

	localparam int NUM_AXES = 3;
	localparam int RAND_ITEMS = 1000;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 300;
	// index past the register list
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [31:0] vx, vy, vz, rx, ry, rz;
	} estimate_t;

	typedef struct packed {
		logic signed [15:0] mx, my, mz;
		logic               check_fixed;
		estimate_t          fixed_est;
	} sample_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] meas_x, meas_y, meas_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] value_x, value_y, value_z, rate_x, rate_y, rate_z;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	const_velocity_kalman_filter #(.AXES(NUM_AXES)) dut (.*);

	// filter state mirror
	logic signed [31:0] m_value [3];
	logic signed [31:0] m_rate [3];
	logic signed [31:0] m_cov [3];
	logic signed [31:0] m_q, m_r, m_t, m_k0s, m_k1s;
	logic               m_all, m_fixed;

	estimate_t estimate_q[$];
	int        errors;
	int        idle_cycles;
	int        sender_idle_pct;
	int        recv_stall_pct;

	initial clk = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [31:0] sat(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return SAT_MAX;
		if (v < -66'sd2147483648) return SAT_MIN;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] fx_add(input logic signed [31:0] a, b);
		return sat(66'(a) + 66'(b));
	endfunction

	function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a, b);
		return sat(66'(a) - 66'(b));
	endfunction

	// arithmetic shift is floor rounding
	function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a, b);
		logic signed [65:0] p;
		p = 66'(a) * 66'(b);
		return sat(p >>> 16);
	endfunction

	function automatic logic signed [31:0] fx_div(input logic signed [31:0] n, d);
		logic signed [65:0] num;
		if (d == 0) return 0;
		num = 66'(n) <<< 16;
		return sat(num / 66'(d));
	endfunction

	task automatic reset_mirror();
		for (int i = 0; i < 3; i++) begin
			m_value[i] = 0;
			m_rate[i] = 0;
			m_cov[i] = 0;
		end
		m_q = 655;
		m_r = 65536;
		m_t = 655;
		m_all = 1'b1;
		m_fixed = 1'b0;
		m_k0s = 1628;
		m_k1s = 20465;
	endtask

	task automatic mirror_config(input logic [2:0] idx, input logic [31:0] d);
		case (idx)
			REG_PROC_NOISE: m_q = {1'b0, d[30:0]};
			REG_MEAS_NOISE: m_r = {1'b0, d[30:0]};
			REG_SAMPLE_PER: m_t = {1'b0, d[30:0]};
			REG_ALL_AXES:   m_all = d[0];
			REG_FIXED_GAIN: m_fixed = d[0];
			REG_GAIN_VALUE: m_k0s = {15'd0, d[16:0]};
			REG_GAIN_RATE:  m_k1s = {15'd0, d[16:0]};
			default: ;
		endcase
	endtask

	// one filter step on the mirror; returns the estimates after it
	function automatic estimate_t kalman_step(input logic signed [15:0] mx, my, mz);
		logic signed [31:0] k0, k1, p00, p01, p11, den, tp01, om, k1p01;
		logic signed [31:0] zq, pred, inn, v, r;
		logic signed [15:0] meas [3];
		int order [3];
		int n, a;
		estimate_t e;
		meas[0] = mx;
		meas[1] = my;
		meas[2] = mz;
		order[0] = 1;
		order[1] = 0;
		order[2] = 2;
		p00 = 0;
		p01 = 0;
		p11 = 0;
		den = 0;
		if (m_fixed) begin
			k0 = m_k0s;
			k1 = m_k1s;
		end else begin
			tp01 = fx_mul(m_t, m_cov[1]);
			p00 = fx_add(fx_add(m_cov[0], fx_add(tp01, tp01)),
				fx_mul(fx_mul(m_t, m_t), m_cov[2]));
			p01 = fx_add(m_cov[1], fx_mul(m_t, m_cov[2]));
			p11 = fx_add(m_cov[2], m_q);
			den = fx_add(p00, m_r);
			k0 = fx_div(p00, den);
			k1 = fx_div(p01, den);
		end
		n = m_all ? NUM_AXES : 1;
		for (int i = 0; i < n; i++) begin
			a = order[i];
			zq = {meas[a], 16'd0};
			v = m_value[a];
			r = m_rate[a];
			pred = fx_add(v, fx_mul(m_t, r));
			inn = fx_sub(zq, pred);
			m_value[a] = fx_add(pred, fx_mul(k0, inn));
			m_rate[a] = fx_add(r, fx_mul(k1, inn));
		end
		if (!m_fixed) begin
			om = fx_sub(ONE_Q16, k0);
			k1p01 = fx_mul(k1, p01);
			m_cov[0] = fx_add(fx_mul(fx_mul(om, om), p00), fx_mul(fx_mul(k0, k0), m_r));
			m_cov[1] = fx_sub(fx_add(fx_mul(fx_mul(k0, k1), den), fx_mul(om, p01)),
				fx_mul(k1, p00));
			m_cov[2] = fx_add(fx_sub(fx_mul(fx_mul(k1, k1), den), fx_add(k1p01, k1p01)),
				p11);
		end
		e.vx = m_value[0];
		e.vy = m_value[1];
		e.vz = m_value[2];
		e.rx = m_rate[0];
		e.ry = m_rate[1];
		e.rz = m_rate[2];
		return e;
	endfunction

	// result check at the rising edge
	always @(posedge clk) begin
		estimate_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (estimate_q.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				e = estimate_q.pop_front();
				if (value_x !== e.vx) begin
					$error("value_x exp %0d got %0d", e.vx, value_x); errors++;
				end
				if (value_y !== e.vy) begin
					$error("value_y exp %0d got %0d", e.vy, value_y); errors++;
				end
				if (value_z !== e.vz) begin
					$error("value_z exp %0d got %0d", e.vz, value_z); errors++;
				end
				if (rate_x !== e.rx) begin
					$error("rate_x exp %0d got %0d", e.rx, rate_x); errors++;
				end
				if (rate_y !== e.ry) begin
					$error("rate_y exp %0d got %0d", e.ry, rate_y); errors++;
				end
				if (rate_z !== e.rz) begin
					$error("rate_z exp %0d got %0d", e.rz, rate_z); errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver stall
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// valid stays up after the transaction; the next task or drain lowers it
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		mirror_config(idx, d);
		@(negedge clk);
	endtask

	task automatic send_sample(input logic signed [15:0] mx, my, mz,
			input logic check_fixed, input estimate_t fixed_est);
		estimate_t e;
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		meas_x <= mx;
		meas_y <= my;
		meas_z <= mz;
		do @(posedge clk); while (in_stall);
		e = kalman_step(mx, my, mz);
		if (check_fixed && e !== fixed_est) begin
			$error("directed row mismatch, exp %h got %h", fixed_est, e);
			errors++;
		end
		estimate_q.push_back(e);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (estimate_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_meas();
		case ($urandom_range(3))
			0: return 16'sh7fff;
			1: return -16'sh8000;
			2: return $signed(16'($urandom_range(200))) - 16'sd100;
			default: return 16'($urandom);
		endcase
	endfunction

	sample_row_t directed [] = '{
		'{16'sd0, 16'sd0, 16'sd0, 1'b1, '0},
		'{16'sh7fff, -16'sh8000, 16'sh7fff, 1'b0, '0},
		'{-16'sh8000, 16'sh7fff, -16'sh8000, 1'b0, '0},
		'{16'sd1, -16'sd1, 16'sd100, 1'b0, '0},
		'{16'sh5555, -16'sh5556, 16'sh0f0f, 1'b0, '0}
	};

	initial begin
		estimate_t none;
		logic [31:0] big;
		none = '0;
		errors = 0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PROC_NOISE;
		cfg_data = '0;
		meas_x = '0;
		meas_y = '0;
		meas_z = '0;
		reset_mirror();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: defaults
		foreach (directed[i])
			send_sample(directed[i].mx, directed[i].my, directed[i].mz,
				directed[i].check_fixed, directed[i].fixed_est);
		drain();
		// y only, fixed gains, including large stored gains
		write_reg(REG_ALL_AXES, 32'd0);
		write_reg(REG_FIXED_GAIN, 32'd1);
		write_reg(REG_GAIN_VALUE, 32'h1ffff);
		write_reg(REG_GAIN_RATE, 32'h10000);
		write_reg(REG_UNUSED, 32'hffffffff);
		foreach (directed[i])
			send_sample(directed[i].my, directed[i].mx, directed[i].mz, 1'b0, none);
		drain();
		write_reg(REG_FIXED_GAIN, 32'd0);
		write_reg(REG_ALL_AXES, 32'd1);
		write_reg(REG_MEAS_NOISE, 32'd0);
		write_reg(REG_PROC_NOISE, 32'd0);
		write_reg(REG_SAMPLE_PER, 32'd0);
		send_sample(16'sd5, 16'sd5, 16'sd5, 1'b0, none);
		send_sample(-16'sd7, 16'sh7fff, 16'sd3, 1'b0, none);
		drain();
		write_reg(REG_PROC_NOISE, 32'h7fffffff);
		write_reg(REG_MEAS_NOISE, 32'hffffffff);
		write_reg(REG_SAMPLE_PER, 32'h7fffffff);
		for (int i = 0; i < 6; i++) send_sample(rand_meas(), rand_meas(), rand_meas(), 1'b0, none);
		drain();

		// random phases with varied pacing and settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
				1: begin sender_idle_pct = 85; recv_stall_pct = 0; end
				2: begin sender_idle_pct = 0; recv_stall_pct = 85; end
				default: begin sender_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			write_reg(REG_PROC_NOISE, ($urandom_range(1)) ? $urandom_range(5000) : $urandom);
			write_reg(REG_MEAS_NOISE, ($urandom_range(1)) ? $urandom_range(200000) : $urandom);
			big = $urandom;
			write_reg(REG_SAMPLE_PER, (ph % 3 == 0) ? big : $urandom_range(70000));
			write_reg(REG_ALL_AXES, $urandom);
			write_reg(REG_FIXED_GAIN, (ph % 2));
			write_reg(REG_GAIN_VALUE, $urandom);
			write_reg(REG_GAIN_RATE, ($urandom_range(1)) ? $urandom_range(65536) : $urandom);
			for (int i = 0; i < RAND_ITEMS / 8; i++)
				send_sample(rand_meas(), rand_meas(), rand_meas(), 1'b0, none);
			sender_idle_pct = 0;
			recv_stall_pct = 0;
			drain();
		end

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
